### hdl/lcf_pkg.sv
// Shared types, constants and the sigmoid table of the LSTM cell block.
package lcf_pkg;

  // Arithmetic and sizing
  localparam int FRAC_BITS_DEF = 12;
  localparam int MAX_INPUT     = 64;
  localparam int MAX_HIDDEN    = 64;
  localparam int IN_CAP        = (MAX_INPUT < 64) ? MAX_INPUT : 64;
  localparam int VEC_DEPTH     = 64;
  localparam int GATE_DEPTH    = 256;
  localparam int WT_DEPTH      = 129 * 256;
  localparam int CELL_W        = 24;

  localparam logic [7:0] BIAS_ROW = 8'd128;
  localparam logic [7:0] REC_BASE = 8'd64;

  // Input command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ELEM  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Job kinds passed from front to back
  localparam logic [1:0] JOB_LOAD  = 2'd0;
  localparam logic [1:0] JOB_ELEM  = 2'd1;
  localparam logic [1:0] JOB_START = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INPUT_SIZE  = 2'd0;
  localparam logic [1:0] REG_HIDDEN_SIZE = 2'd1;
  localparam logic [1:0] REG_MAX_STEPS   = 2'd2;
  localparam logic [1:0] REG_EMIT_EVERY  = 2'd3;

  typedef struct packed {
    logic [6:0]  n_in;
    logic [6:0]  h;
    logic [15:0] max_steps;
    logic        emit_every;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] waddr;
    logic [15:0] value;
    logic [5:0]  idx;
    logic        close;
    logic        seq_end;
  } job_t;

  typedef struct packed {
    logic [5:0]  unit;
    logic [15:0] hidden;
    logic [15:0] step;
    logic        last;
  } res_t;

  // sigmoid(k/2) in units of 2^-16
  function automatic logic [16:0] sig_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd40793;
      5'd2:    v = 17'd47911;
      5'd3:    v = 17'd53581;
      5'd4:    v = 17'd57724;
      5'd5:    v = 17'd60565;
      5'd6:    v = 17'd62428;
      5'd7:    v = 17'd63615;
      5'd8:    v = 17'd64357;
      5'd9:    v = 17'd64816;
      5'd10:   v = 17'd65097;
      5'd11:   v = 17'd65269;
      5'd12:   v = 17'd65374;
      5'd13:   v = 17'd65438;
      5'd14:   v = 17'd65476;
      5'd15:   v = 17'd65500;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

endpackage

### hdl/lcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/lcf_fifo.sv
// Small register FIFO used for the job queue and the result queue.
module lcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // store words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/lcf_front.sv
// Front end: takes input words, drops the ones with no effect and forms jobs.
module lcf_front (
  input  logic         push,
  input  logic         full,
  input  logic [1:0]   cmd,
  input  logic [7:0]   weight_row,
  input  logic [7:0]   weight_col,
  input  logic [15:0]  weight_value,
  input  logic [5:0]   elem_index,
  input  logic [15:0]  elem_value,
  input  logic         sequence_end,
  input  lcf_pkg::cfg_t cfg,
  output logic         job_push,
  output lcf_pkg::job_t job
);
  import lcf_pkg::*;

  logic take;

  assign take = push && !full;

  // classify the word
  always_comb begin
    job          = '0;
    job.waddr    = {weight_row, weight_col};
    job.idx      = elem_index;
    job.seq_end  = sequence_end;
    job.value    = weight_value;
    job_push     = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        job.kind = JOB_LOAD;
        job_push = take && (weight_row <= BIAS_ROW);
      end
      CMD_ELEM: begin
        job.kind  = JOB_ELEM;
        job.value = elem_value;
        job.close = ({1'b0, elem_index} == (cfg.n_in - 7'd1));
        job_push  = take;
      end
      CMD_START: begin
        job.kind = JOB_START;
        job_push = take;
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

endmodule

### hdl/lcf_act.sv
// Two-stage sigmoid / tanh unit: table lookup with linear interpolation.
module lcf_act #(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk,
  input  logic signed [31:0]        a,
  input  logic                      tanh_m,
  output logic signed [FRAC_BITS+1:0] res
);
  import lcf_pkg::*;

  localparam int ACT_W = FRAC_BITS + 2;
  localparam int SH    = FRAC_BITS - 1;
  localparam int PR_W  = 14 + SH;
  localparam logic [17:0] RND = 18'(1) << (15 - FRAC_BITS);

  logic signed [32:0] a33;
  logic [32:0]        mag;
  logic [33:0]        m34, khi;
  logic [3:0]         k;
  logic [SH-1:0]      fr;
  logic [16:0]        t0, t1, diff;
  logic [PR_W-1:0]    prod;

  logic [16:0]        base_q;
  logic [PR_W-1:0]    prod_q;
  logic               sat_q, neg_q, tanh_q;

  logic [16:0]        mag16;
  logic [17:0]        q18, rnd;
  logic [ACT_W-1:0]   r;

  // stage A: magnitude, table lookup, interpolation product
  assign a33  = 33'(a);
  assign mag  = a[31] ? $unsigned(-a33) : $unsigned(a33);
  assign m34  = tanh_m ? {mag, 1'b0} : {1'b0, mag};
  assign khi  = m34 >> SH;
  assign k    = khi[3:0];
  assign fr   = m34[SH-1:0];
  assign t0   = sig_tab({1'b0, k});
  assign t1   = sig_tab({1'b0, k} + 5'd1);
  assign diff = t1 - t0;
  assign prod = PR_W'(diff[13:0]) * PR_W'(fr);

  always_ff @(posedge clk) begin
    base_q <= t0;
    prod_q <= prod;
    sat_q  <= (khi >= 34'd16);
    neg_q  <= a[31];
    tanh_q <= tanh_m;
  end

  // stage B: finish interpolation, fold sign, round to the fraction width
  assign mag16 = sat_q ? sig_tab(5'd16) : base_q + 17'(prod_q >> SH);
  assign q18   = tanh_q ? ({mag16, 1'b0} - 18'd65536)
               : (neg_q ? (18'd65536 - {1'b0, mag16}) : {1'b0, mag16});
  assign rnd   = (q18 + RND) >> (16 - FRAC_BITS);
  assign r     = rnd[ACT_W-1:0];

  always_ff @(posedge clk) begin
    res <= (tanh_q && neg_q) ? -$signed(r) : $signed(r);
  end

endmodule

### hdl/lcf_back.sv
// Back end: runs jobs, gate MAC sweep, cell update and hidden emission.
module lcf_back #(
  parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lcf_pkg::cfg_t cfg,
  input  lcf_pkg::job_t job,
  input  logic          job_empty,
  output logic          job_pop,
  output lcf_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);
  import lcf_pkg::*;

  localparam int ACT_W = FRAC_BITS + 2;
  localparam int PW    = CELL_W + ACT_W + 1;
  localparam int HW    = 2 * ACT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [3:0] PH_LAST = 4'd11;

  logic [2:0]  state;
  logic [15:0] step_cnt;
  logic        seq_q;
  logic [7:0]  t, col;
  logic [5:0]  u, eu;
  logic [3:0]  ph;
  logic        e_ph;
  logic [VEC_DEPTH-1:0] hvalid, cvalid;

  logic [7:0]  n8, h8, hx2, hx3, t_last, col_last, tm1, rec_off, row;
  logic [8:0]  col_last9;

  // RAM ports
  logic [15:0] w_rd, in_rd, h_rd;
  logic [31:0] g_rd;
  logic [CELL_W-1:0] c_rd;
  logic [5:0]  hid_raddr;
  logic [7:0]  g_raddr;
  logic        w_we, in_we, g_we, c_we, h_we;

  // MAC pipeline
  logic        v1, bias1, rec1, last1, hv_q;
  logic [7:0]  col1;
  logic        v2, first2, last2;
  logic [7:0]  col2;
  logic signed [31:0] prod2, acc, acc_sum, mulv, bias_ext;
  logic signed [15:0] wsx, vsel;

  // update datapath
  logic signed [31:0]       act_in;
  logic                     act_tanh;
  logic signed [ACT_W-1:0]  act_res, f_q, i_q, g_q, o_q;
  logic                     cv_q;
  logic signed [CELL_W-1:0] c_old, c_new_q, c_new;
  logic signed [PW-1:0]     p1, p2, csum, csh;
  logic signed [HW-1:0]     p3, hsh;
  logic [15:0]              h_new;

  logic take;

  assign n8        = {1'b0, cfg.n_in};
  assign h8        = {1'b0, cfg.h};
  assign hx2       = h8 << 1;
  assign hx3       = hx2 + h8;
  assign t_last    = n8 + h8;
  assign col_last9 = ({2'b0, cfg.h} << 2) - 9'd1;
  assign col_last  = col_last9[7:0];
  assign tm1       = t - 8'd1;
  assign rec_off   = tm1 - n8;

  assign take    = (state == S_IDLE) && !job_empty;
  assign job_pop = take;

  // weight row of the term being issued
  always_comb begin
    if (t == 8'd0) begin
      row = BIAS_ROW;
    end else if (t <= n8) begin
      row = tm1;
    end else begin
      row = REC_BASE + rec_off;
    end
  end

  assign hid_raddr = (state == S_EMIT) ? eu : rec_off[5:0];

  always_comb begin
    case (ph)
      4'd1:    g_raddr = h8 + {2'b0, u};
      4'd2:    g_raddr = hx2 + {2'b0, u};
      4'd3:    g_raddr = hx3 + {2'b0, u};
      default: g_raddr = {2'b0, u};
    endcase
  end

  assign w_we  = take && (job.kind == JOB_LOAD);
  assign in_we = take && (job.kind == JOB_ELEM);
  assign g_we  = v2 && last2;
  assign c_we  = (state == S_UPD) && (ph == 4'd8);
  assign h_we  = (state == S_UPD) && (ph == PH_LAST);

  lcf_ram #(.WIDTH(16), .DEPTH(WT_DEPTH)) u_wt (
    .clk(clk), .we(w_we), .waddr(job.waddr), .wdata(job.value),
    .raddr({row, col}), .rdata(w_rd)
  );

  lcf_ram #(.WIDTH(16), .DEPTH(VEC_DEPTH)) u_in (
    .clk(clk), .we(in_we), .waddr(job.idx), .wdata(job.value),
    .raddr(tm1[5:0]), .rdata(in_rd)
  );

  lcf_ram #(.WIDTH(16), .DEPTH(VEC_DEPTH)) u_hid (
    .clk(clk), .we(h_we), .waddr(u), .wdata(h_new),
    .raddr(hid_raddr), .rdata(h_rd)
  );

  lcf_ram #(.WIDTH(CELL_W), .DEPTH(VEC_DEPTH)) u_cell (
    .clk(clk), .we(c_we), .waddr(u), .wdata(c_new_q),
    .raddr(u), .rdata(c_rd)
  );

  lcf_ram #(.WIDTH(32), .DEPTH(GATE_DEPTH)) u_gate (
    .clk(clk), .we(g_we), .waddr(col2), .wdata(acc_sum),
    .raddr(g_raddr), .rdata(g_rd)
  );

  // MAC: product of weight and operand, bias scaled up so one shift serves all
  assign wsx      = $signed(w_rd);
  assign vsel     = rec1 ? (hv_q ? $signed(h_rd) : 16'sd0) : $signed(in_rd);
  assign mulv     = wsx * vsel;
  assign bias_ext = 32'(wsx) <<< FRAC_BITS;
  assign acc_sum  = (first2 ? 32'sd0 : acc) + (prod2 >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    hv_q  <= hvalid[hid_raddr];
    bias1 <= (t == 8'd0);
    rec1  <= (t > n8);
    last1 <= (t == t_last);
    col1  <= col;
    prod2  <= bias1 ? bias_ext : mulv;
    first2 <= bias1;
    last2  <= last1;
    col2   <= col1;
    if (v2) begin
      acc <= acc_sum;
    end
  end

  // activation unit shared by all gates and the cell tanh
  assign act_in   = (ph == 4'd8) ? 32'(c_new_q) : $signed(g_rd);
  assign act_tanh = (ph == 4'd3) || (ph == 4'd8);

  lcf_act #(.FRAC_BITS(FRAC_BITS)) u_act (
    .clk(clk), .a(act_in), .tanh_m(act_tanh), .res(act_res)
  );

  // cell saturation to 24 bits
  assign csum = p1 + p2;
  assign csh  = csum >>> FRAC_BITS;
  always_comb begin
    if (!csh[PW-1] && (|csh[PW-2:CELL_W-1])) begin
      c_new = {1'b0, {(CELL_W-1){1'b1}}};
    end else if (csh[PW-1] && !(&csh[PW-2:CELL_W-1])) begin
      c_new = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      c_new = csh[CELL_W-1:0];
    end
  end

  // hidden saturation to 16 bits
  assign hsh = p3 >>> FRAC_BITS;
  always_comb begin
    if (!hsh[HW-1] && (|hsh[HW-2:15])) begin
      h_new = 16'h7FFF;
    end else if (hsh[HW-1] && !(&hsh[HW-2:15])) begin
      h_new = 16'h8000;
    end else begin
      h_new = hsh[15:0];
    end
  end

  // update datapath registers, stepped through the update phases for each unit
  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      case (ph)
        4'd0: cv_q <= cvalid[u];
        4'd1: c_old <= cv_q ? $signed(c_rd) : '0;
        4'd3: f_q <= act_res;
        4'd4: i_q <= act_res;
        4'd5: g_q <= act_res;
        4'd6: begin
          o_q <= act_res;
          p1  <= f_q * c_old;
          p2  <= i_q * g_q;
        end
        4'd7:  c_new_q <= c_new;
        4'd10: p3 <= o_q * act_res;
        default: begin
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res.unit   = eu;
    res.hidden = hv_q ? h_rd : 16'd0;
    res.step   = step_cnt;
    res.last   = seq_q && ({1'b0, eu} == (cfg.h - 7'd1));
  end
  assign res_push = (state == S_EMIT) && e_ph;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
      hvalid   <= '0;
      cvalid   <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      t        <= '0;
      col      <= '0;
      u        <= '0;
      ph       <= '0;
      eu       <= '0;
      e_ph     <= 1'b0;
      seq_q    <= 1'b0;
    end else begin
      v1 <= (state == S_MAC);
      v2 <= v1;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (job.kind == JOB_START) begin
              hvalid   <= '0;
              cvalid   <= '0;
              step_cnt <= '0;
            end else if (job.kind == JOB_ELEM && job.close) begin
              seq_q <= job.seq_end;
              t     <= '0;
              col   <= '0;
              eu    <= '0;
              e_ph  <= 1'b0;
              if (step_cnt < cfg.max_steps) begin
                state <= S_MAC;
              end else if (!cfg.emit_every && job.seq_end) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_MAC: begin
          if (t == t_last) begin
            t <= '0;
            if (col == col_last) begin
              state <= S_DRAIN;
            end else begin
              col <= col + 8'd1;
            end
          end else begin
            t <= t + 8'd1;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            u     <= '0;
            ph    <= '0;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (ph == 4'd8) begin
            cvalid[u] <= 1'b1;
          end
          if (ph == PH_LAST) begin
            hvalid[u] <= 1'b1;
            ph        <= '0;
            if ({1'b0, u} == (cfg.h - 7'd1)) begin
              step_cnt <= step_cnt + 16'd1;
              state    <= (cfg.emit_every || seq_q) ? S_EMIT : S_IDLE;
            end else begin
              u <= u + 6'd1;
            end
          end else begin
            ph <= ph + 4'd1;
          end
        end
        S_EMIT: begin
          if (!e_ph) begin
            if (!res_full) begin
              e_ph <= 1'b1;
            end
          end else begin
            e_ph <= 1'b0;
            if ({1'b0, eu} == (cfg.h - 7'd1)) begin
              state <= S_IDLE;
            end else begin
              eu <= eu + 6'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/lstm_cell_forward.sv
// Top level of the LSTM cell block: configuration, front, job queue, back, result queue.
//
// Usage. Input words enter by push while full is low; cmd selects a weight load
// (row, column, value), an input element (index, value, sequence end) or a
// sequence start. Results leave by pop while empty is low: one word per hidden
// unit, unit_index 0 first, each with step_number; last marks a sequence's final unit.
// Config writes use cfg_valid / cfg_ready (always ready), cfg_index and cfg_data;
// the user must make them only while the block is idle, which the block never checks.
// Operation. Load, element and start jobs are taken only while the back end is idle. The
// element that closes a vector, while the step count is below max_steps, starts
// 4*H*(N+H+1) gate multiply-accumulates, one weight-store read per cycle, then a
// pipeline drain and the cell update of each unit through the shared activation unit
// and multipliers; results are emitted when emit-every-step is set or at sequence end.
// A two-word job queue lets the input side run ahead of the back end.
// Reset clears the queues, the step counter and the valid bits of the cell and
// hidden stores, so both read as zero; there is no clearing pass. The weight
// store and input buffer hold garbage until written. When pop stays low the
// four-word result queue fills and the back end holds until space opens.
module lstm_cell_forward #(
  parameter int FRAC_BITS = lcf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  weight_row,
  input  logic [7:0]  weight_col,
  input  logic [15:0] weight_value,
  input  logic [5:0]  elem_index,
  input  logic [15:0] elem_value,
  input  logic        sequence_end,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  unit_index,
  output logic [15:0] hidden_value,
  output logic [15:0] step_number,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcf_pkg::*;

  logic [6:0]  input_size, hidden_size;
  logic [15:0] max_steps;
  logic        emit_every_step;
  cfg_t        cfg;

  job_t job_in, job_out;
  logic job_push, job_pop, job_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_size      <= 7'd64;
      hidden_size     <= 7'd64;
      max_steps       <= 16'hFFFF;
      emit_every_step <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_SIZE:  input_size      <= cfg_data[6:0];
        REG_HIDDEN_SIZE: hidden_size     <= cfg_data[6:0];
        REG_MAX_STEPS:   max_steps       <= cfg_data;
        REG_EMIT_EVERY:  emit_every_step <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // clamp sizes to the supported range
  always_comb begin
    cfg.n_in = (input_size == 7'd0) ? 7'd1
             : ((input_size > 7'(IN_CAP)) ? 7'(IN_CAP) : input_size);
    cfg.h    = (hidden_size == 7'd0) ? 7'd1
             : ((hidden_size > 7'(MAX_HIDDEN)) ? 7'(MAX_HIDDEN) : hidden_size);
    cfg.max_steps  = max_steps;
    cfg.emit_every = emit_every_step;
  end

  lcf_front u_front (
    .push(push), .full(full), .cmd(cmd), .weight_row(weight_row),
    .weight_col(weight_col), .weight_value(weight_value),
    .elem_index(elem_index), .elem_value(elem_value),
    .sequence_end(sequence_end), .cfg(cfg), .job_push(job_push), .job(job_in)
  );

  lcf_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_jobq (
    .clk(clk), .rst(rst), .push(job_push), .wdata(job_in), .full(full),
    .pop(job_pop), .rdata(job_out), .empty(job_empty)
  );

  lcf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job(job_out), .job_empty(job_empty),
    .job_pop(job_pop), .res(res_in), .res_push(res_push), .res_full(res_full)
  );

  lcf_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_resq (
    .clk(clk), .rst(rst), .push(res_push), .wdata(res_in), .full(res_full),
    .pop(pop), .rdata(res_out), .empty(empty)
  );

  assign unit_index   = res_out.unit;
  assign hidden_value = res_out.hidden;
  assign step_number  = res_out.step;
  assign last         = res_out.last;

endmodule

### hdl/lcf_checker.sv
// Port checker for the LSTM cell block, bound to the top level.
module lcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [5:0]  unit_index,
  input logic [15:0] hidden_value,
  input logic        last
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(unit_index) && $stable(hidden_value)))
    else $error("waiting result word changed");

  // units of one run come out in ascending order
  a_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last) |=>
      (empty || unit_index == $past(unit_index) + 6'd1 || unit_index == 6'd0))
    else $error("result units out of order");

endmodule

bind lstm_cell_forward lcf_checker u_lcf_checker (.*);
